/* sv/mfa_pkg.sv */
package mfa_pkg;

   // Field widths of the feedback frame and of the result
   localparam int ID_W        = 11;
   localparam int PAYLOAD_W   = 64;
   localparam int ANGLE_W     = 16;
   localparam int SAMPLE_W    = 16;
   localparam int TEMP_W      = 8;
   localparam int MOTOR_OUT_W = 2;

   // Stream packing, padded to whole bytes
   localparam int REQ_DATA_W = 80;   // frame_id, payload
   localparam int RSP_DATA_W = 72;   // angle, previous_angle, averages, temperature
   localparam int RSP_USER_W = 8;    // motor_index

   // Window RAM word: speed in the low half, current in the high half
   localparam int RAM_W = 2 * SAMPLE_W;

   localparam logic [ID_W-1:0] BASE_ID_RESET = 11'd513;

   // Averaging lanes
   localparam int LANE_SPEED   = 0;
   localparam int LANE_CURRENT = 1;
   localparam int LANES        = 2;

   // Per-frame fields carried alongside the window arithmetic
   typedef struct packed {
      logic [MOTOR_OUT_W-1:0] motor;
      logic [ANGLE_W-1:0]     angle;
      logic [ANGLE_W-1:0]     prev_angle;
      logic [TEMP_W-1:0]      temperature;
   } frame_info_type;

endpackage

/* sv/mfa_ram.sv */
module mfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 40,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/motor_feedback_frame_averager_core.sv */
// Channel   | Direction | Transfer contents (low bits first)
// ----------+-----------+-------------------------------------------------------------
// req_      | in        | tdata: frame_id[10:0], payload[74:11], zero pad to 80 bits
// rsp_      | out       | tdata: angle, previous_angle, speed_average, current_average,
//           |           |        temperature; tuser: motor_index[1:0]
// csr_      | in        | wr_data: base_identifier, written when wr_en is high
//
// One frame per cycle sustained while rsp_ is not stalled; a kept frame reaches rsp_
// through the window RAM read at its transfer, then running-sum update, reciprocal
// multiply, and correction into the output register.
// Reset clears the running sums, write positions, previous angles and the valid bit
// of every window slot at once, so frames are taken as soon as reset is released.
// Each stage moves when the stage after it is empty or moving, so input transfers
// continue while a result waits on rsp_ until the pipeline is full.
module motor_feedback_frame_averager_core
   import mfa_pkg::*;
#(
   parameter int WINDOW = 10,
   parameter int MOTORS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // frame_id[10:0], payload[74:11]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // angle[15:0], previous_angle[31:16], speed_average[47:32],
   // current_average[63:48], temperature[71:64]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // motor_index[1:0]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_wr_en,
   input  logic [ID_W-1:0]       csr_wr_data
);

   localparam int POS_W  = $clog2(WINDOW);
   localparam int MI_W   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam int DEPTH  = MOTORS * WINDOW;
   localparam int ADDR_W = $clog2(DEPTH);
   // Magnitude of a window sum; the sum itself carries one more bit for sign
   localparam int MAG_W  = SAMPLE_W + $clog2(WINDOW);
   localparam int SUM_W  = MAG_W + 1;
   // floor(2^MAG_W / WINDOW): the quotient estimate is at most one short
   localparam logic [MAG_W-1:0] RECIP   = MAG_W'((64'd1 << MAG_W) / WINDOW);
   localparam logic [MAG_W-1:0] WIN_MAG = MAG_W'(WINDOW);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

   // ------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------
   logic [ID_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_ID_RESET;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Stage enables: a stage moves when the next one is empty or moving
   // ------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, rsp_v_ff;
   logic en_out, en3, en2, en1;

   assign en_out = !rsp_v_ff || rsp_tready;
   assign en3    = !s3_v_ff || en_out;
   assign en2    = !s2_v_ff || en3;
   assign en1    = !s1_v_ff || en2;

   assign req_tready = en1;

   // ------------------------------------------------------------------
   // Stage 0: decode the frame, claim the window slot, issue the RAM read
   // ------------------------------------------------------------------
   logic [ID_W-1:0]      req_id;
   logic [PAYLOAD_W-1:0] req_payload;
   logic [ID_W-1:0]      id_diff;
   logic                 kept;
   logic                 take;
   logic [MI_W-1:0]      req_motor;
   logic [POS_W-1:0]     cur_pos;
   logic [POS_W-1:0]     pos_in;
   logic [ADDR_W-1:0]    rd_addr;
   frame_info_type       info0;

   logic [POS_W-1:0]   pos_ff   [MOTORS];
   logic [ANGLE_W-1:0] angle_ff [MOTORS];

   assign req_id      = req_tdata[ID_W-1:0];
   assign req_payload = req_tdata[ID_W +: PAYLOAD_W];
   assign id_diff     = req_id - base_ff;
   // The identifier range does not wrap past the top code
   assign kept        = (req_id >= base_ff) && (id_diff < ID_W'(MOTORS));
   assign take        = req_tvalid && en1 && kept;
   assign req_motor   = id_diff[MI_W-1:0];
   assign cur_pos     = pos_ff[req_motor];
   assign pos_in      = (cur_pos == POS_LAST) ? '0 : cur_pos + 1'b1;
   assign rd_addr     = ADDR_W'(ADDR_W'(req_motor) * ADDR_W'(WINDOW)) + ADDR_W'(cur_pos);

   always_comb begin
      info0.motor       = MOTOR_OUT_W'(req_motor);
      info0.angle       = req_payload[63:48];
      info0.prev_angle  = angle_ff[req_motor];
      info0.temperature = req_payload[15:8];
   end

   // Position and previous angle are settled at the transfer itself, so a
   // following frame for the same motor already sees them.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOTORS; i++) begin
            pos_ff[i]   <= '0;
            angle_ff[i] <= '0;
         end
      end else if (take) begin
         pos_ff[req_motor]   <= pos_in;
         angle_ff[req_motor] <= info0.angle;
      end
   end

   // ------------------------------------------------------------------
   // Window RAM: one slot per motor and position, both samples in a word
   // ------------------------------------------------------------------
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [RAM_W-1:0]    ram_wr_data;
   logic [RAM_W-1:0]    ram_rd_data;

   mfa_ram #(
      .WIDTH (RAM_W),
      .DEPTH (DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (take),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Stage 1: retire the oldest sample, fold in the new one
   // ------------------------------------------------------------------
   logic [MI_W-1:0]            s1_motor_ff;
   logic signed [SAMPLE_W-1:0] s1_new_ff [LANES];
   frame_info_type             s1_info_ff;

   logic [DEPTH-1:0]           slot_valid_ff;
   logic signed [SUM_W-1:0]    sum_ff [LANES][MOTORS];

   logic signed [SAMPLE_W-1:0] old_sample [LANES];
   logic signed [SUM_W-1:0]    sum_in [LANES];
   logic                       commit1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en1) begin
         s1_v_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_motor_ff                <= req_motor;
         s1_addr_ff                 <= rd_addr;
         s1_new_ff[LANE_SPEED]      <= req_payload[47:32];
         s1_new_ff[LANE_CURRENT]    <= req_payload[31:16];
         s1_info_ff                 <= info0;
      end
   end

   assign commit1 = s1_v_ff && en2;
   assign ram_wr_en = commit1;
   assign ram_wr_data = {s1_new_ff[LANE_CURRENT], s1_new_ff[LANE_SPEED]};

   always_comb begin
      // A slot never written since reset counts as zero
      old_sample[LANE_SPEED]   = slot_valid_ff[s1_addr_ff] ? ram_rd_data[SAMPLE_W-1:0] : '0;
      old_sample[LANE_CURRENT] = slot_valid_ff[s1_addr_ff] ? ram_rd_data[RAM_W-1:SAMPLE_W]
                                                           : '0;
      for (int l = 0; l < LANES; l++) begin
         sum_in[l] = sum_ff[l][s1_motor_ff] - SUM_W'(old_sample[l]) + SUM_W'(s1_new_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         for (int l = 0; l < LANES; l++) begin
            for (int i = 0; i < MOTORS; i++) begin
               sum_ff[l][i] <= '0;
            end
         end
      end else if (commit1) begin
         slot_valid_ff[s1_addr_ff] <= 1'b1;
         for (int l = 0; l < LANES; l++) begin
            sum_ff[l][s1_motor_ff] <= sum_in[l];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: magnitude times reciprocal
   // ------------------------------------------------------------------
   logic signed [SUM_W-1:0] s2_sum_ff [LANES];
   frame_info_type          s2_info_ff;
   logic [MAG_W-1:0]        mag2 [LANES];
   logic [2*MAG_W-1:0]      prod2 [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_sum_ff  <= sum_in;
         s2_info_ff <= s1_info_ff;
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mag2[l]  = s2_sum_ff[l][SUM_W-1] ? MAG_W'(-s2_sum_ff[l]) : MAG_W'(s2_sum_ff[l]);
         prod2[l] = mag2[l] * RECIP;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: correct the estimate by one, restore the sign
   // ------------------------------------------------------------------
   logic [MAG_W-1:0]           s3_q_ff   [LANES];
   logic [MAG_W-1:0]           s3_mag_ff [LANES];
   logic [LANES-1:0]           s3_neg_ff;
   frame_info_type             s3_info_ff;
   logic [MAG_W-1:0]           rem3 [LANES];
   logic [MAG_W-1:0]           q3   [LANES];
   logic signed [SAMPLE_W-1:0] avg3 [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         for (int l = 0; l < LANES; l++) begin
            s3_q_ff[l]   <= prod2[l][2*MAG_W-1:MAG_W];
            s3_mag_ff[l] <= mag2[l];
            s3_neg_ff[l] <= s2_sum_ff[l][SUM_W-1];
         end
         s3_info_ff <= s2_info_ff;
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         rem3[l] = s3_mag_ff[l] - MAG_W'(s3_q_ff[l] * WIN_MAG);
         q3[l]   = (rem3[l] >= WIN_MAG) ? s3_q_ff[l] + 1'b1 : s3_q_ff[l];
         // Sign-magnitude division truncates toward zero
         avg3[l] = s3_neg_ff[l] ? SAMPLE_W'(-q3[l]) : SAMPLE_W'(q3[l]);
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en_out) begin
         rsp_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_data_ff <= {s3_info_ff.temperature,
                         avg3[LANE_CURRENT],
                         avg3[LANE_SPEED],
                         s3_info_ff.prev_angle,
                         s3_info_ff.angle};
         rsp_user_ff <= RSP_USER_W'(s3_info_ff.motor);
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // The slot being retired and the slot being read never coincide
   assert property (@(posedge clock) disable iff (reset)
      (commit1 && take) |-> (s1_addr_ff != rd_addr))
      else $error("window slot read and written in the same cycle");

   // The remainder before correction lies below twice the window size
   assert property (@(posedge clock) disable iff (reset)
      s3_v_ff |-> ((rem3[LANE_SPEED] < (WIN_MAG + WIN_MAG)) &&
                   (rem3[LANE_CURRENT] < (WIN_MAG + WIN_MAG))))
      else $error("reciprocal estimate off by more than one");

   // A kept frame always claims a position inside the window
   assert property (@(posedge clock) disable iff (reset)
      take |-> (cur_pos <= POS_LAST))
      else $error("write position beyond window");

   // An empty first stage never holds off the input
   assert property (@(posedge clock) disable iff (reset)
      !s1_v_ff |-> req_tready)
      else $error("input stalled with stage one empty");

endmodule
